@@ design/assert_macros.svh @@
// Assertion macros used by the integer to text formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/itf_pkg.sv @@
package itf_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;
    localparam int HEX_DIGITS = 16;
    localparam int CHAR_W     = 7;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    typedef enum logic [1:0] {
        CMD_UDEC = 2'd0,
        CMD_SDEC = 2'd1,
        CMD_HEXL = 2'd2,
        CMD_HEXU = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_DSHIFT
    } t_cell_op;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_cmd               cmd;
    } t_in_word;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_out_word;

    // ASCII for one digit; letters only occur in hex mode.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UPPER : CHAR_LOWER;
        if (d < 4'd10) begin
            digit_char = CHAR_ZERO + {3'b000, d};
        end else begin
            digit_char = base + {3'b000, d} - 7'd10;
        end
    endfunction

endpackage

@@ design/itf_cell.sv @@
module itf_cell (
    input  logic             i_clk,
    input  itf_pkg::t_cell_op i_op,
    input  logic [3:0]       i_load_digit,
    input  logic             i_bit,
    input  logic [3:0]       i_digit,
    output logic [3:0]       o_digit,
    output logic             o_bit
);
    import itf_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // Add three before the shift so that the doubled digit carries at ten.
    assign w_adj   = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_bit   = w_adj[3];
    assign o_digit = r_digit;

    always_comb begin
        case (i_op)
            CELL_LOAD:   n_digit = i_load_digit;
            CELL_DABBLE: n_digit = {w_adj[2:0], i_bit};
            CELL_DSHIFT: n_digit = i_digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

@@ design/integer_to_text_formatter.sv @@
// Integer to ASCII text formatter.
// Input channel: i_in_valid / o_in_stall carry one word holding a 64-bit value
// and a conversion code (unsigned decimal, signed decimal, hex lower or upper).
// Output channel: o_out_valid / i_out_stall carry one word per character, most
// significant first, with last set on the final character of the value.
// A word is taken only while the block is idle; it then works on that value alone.
// Decimal conversion runs a chain of twenty BCD digit cells, one value bit per
// cycle (shift and add three). Hex loads the nibbles straight into the cells.
// The chain then shifts one digit per cycle toward the output end, dropping
// leading zeros and handing each kept digit to the output register; a kept
// digit waits while the receiver stalls, but leading zeros drop out even then.
// The first digit is taken later the more leading zeros the value has.
// Stalls on the output hold the output register and pause the digit chain
// once a digit is ready to send.
// Reset is synchronous and active low; it returns the block to idle and drops
// the output valid. No clearing pass is needed.
module integer_to_text_formatter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itf_pkg::t_out_word o_out_word
);
    import itf_pkg::*;

    `include "assert_macros.svh"

    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int REM_W     = $clog2(NUM_DIGITS + 1);

    // Control state.
    t_state                r_state;
    t_state                n_state;
    logic [BIT_CNT_W-1:0]  r_bit_cnt;
    logic [REM_W-1:0]      r_rem;
    logic                  r_started;
    logic                  r_neg;
    logic                  r_upper;
    logic                  r_out_valid;

    // Payload.
    logic [VALUE_W-1:0]    r_shift;
    t_out_word             r_out_word;

    // Handshake and chain signals.
    logic                  w_in_acc;
    logic                  w_slot_free;
    logic                  w_in_neg;
    logic                  w_in_hex;
    logic [VALUE_W-1:0]    w_in_mag;
    logic [3:0]            w_top;
    logic                  w_emit_now;
    logic                  w_skip;
    logic                  w_emit;
    logic                  w_sign;
    t_cell_op              w_cell_op;
    logic [3:0]            w_digit [NUM_DIGITS];
    logic                  w_carry [NUM_DIGITS+1];

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    assign w_in_neg = (i_in_word.cmd == CMD_SDEC) && i_in_word.value[VALUE_W-1];
    assign w_in_hex = (i_in_word.cmd == CMD_HEXL) || (i_in_word.cmd == CMD_HEXU);
    // The two's complement of the most negative value is itself, which read as
    // unsigned is exactly its magnitude.
    assign w_in_mag = w_in_neg ? (~i_in_word.value + 1'b1) : i_in_word.value;

    // The most significant digit sits in the last cell of the chain.
    assign w_top      = w_digit[NUM_DIGITS-1];
    assign w_emit_now = r_started || (w_top != 4'd0) || (r_rem == REM_W'(1));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_in_hex ? ST_EMIT : ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_slot_free) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free && w_emit_now && (r_rem == REM_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output logic: what the chain does this cycle and what the output
    // register takes.
    always_comb begin
        w_skip    = 1'b0;
        w_emit    = 1'b0;
        w_sign    = 1'b0;
        w_cell_op = CELL_HOLD;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    w_cell_op = CELL_LOAD;
                end
            end
            ST_CONV: begin
                w_cell_op = CELL_DABBLE;
            end
            ST_SIGN: begin
                w_sign = w_slot_free;
            end
            ST_EMIT: begin
                // Leading zeros drop out without waiting on the receiver.
                w_skip = !w_emit_now;
                w_emit = w_emit_now && w_slot_free;
                if (w_skip || (w_emit && (r_rem != REM_W'(1)))) begin
                    w_cell_op = CELL_DSHIFT;
                end
            end
            default: begin
                w_cell_op = CELL_HOLD;
            end
        endcase
    end

    assign w_carry[0] = r_shift[VALUE_W-1];

    for (genvar gi = 0; gi < NUM_DIGITS; gi++) begin : g_cell
        logic [3:0] w_load_digit;
        logic [3:0] w_digit_in;

        // Hex nibbles fill the top cells so that the top nibble starts in the
        // last cell, with sixteen positions left to emit.
        if (gi >= NUM_DIGITS - HEX_DIGITS) begin : g_hex
            assign w_load_digit = w_in_hex ?
                i_in_word.value[4*(gi-(NUM_DIGITS-HEX_DIGITS)) +: 4] : 4'd0;
        end else begin : g_dec
            assign w_load_digit = 4'd0;
        end

        if (gi == 0) begin : g_first
            assign w_digit_in = 4'd0;
        end else begin : g_next
            assign w_digit_in = w_digit[gi-1];
        end

        itf_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_cell_op),
            .i_load_digit (w_load_digit),
            .i_bit        (w_carry[gi]),
            .i_digit      (w_digit_in),
            .o_digit      (w_digit[gi]),
            .o_bit        (w_carry[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit_cnt   <= '0;
            r_rem       <= '0;
            r_started   <= 1'b0;
            r_neg       <= 1'b0;
            r_upper     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_bit_cnt <= '0;
                r_rem     <= w_in_hex ? REM_W'(HEX_DIGITS) : REM_W'(NUM_DIGITS);
                r_started <= 1'b0;
                r_neg     <= w_in_neg;
                r_upper   <= (i_in_word.cmd == CMD_HEXU);
            end else begin
                if (r_state == ST_CONV) begin
                    r_bit_cnt <= r_bit_cnt + 1'b1;
                end
                if (w_skip || w_emit) begin
                    r_rem <= r_rem - 1'b1;
                end
                if (w_emit) begin
                    r_started <= 1'b1;
                end
            end
            if (w_emit || w_sign) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_shift <= w_in_mag;
        end else if (r_state == ST_CONV) begin
            r_shift <= {r_shift[VALUE_W-2:0], 1'b0};
        end
        if (w_sign) begin
            r_out_word.char_code <= CHAR_MINUS;
            r_out_word.last      <= 1'b0;
        end else if (w_emit) begin
            r_out_word.char_code <= digit_char(w_top, r_upper);
            r_out_word.last      <= (r_rem == REM_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Twenty digits hold any 64-bit magnitude, so nothing carries out of the
    // top cell while converting.
    `ASSERT_IMPLIES(a_no_top_carry, i_clk, i_rst_n, r_state == ST_CONV,
        !w_carry[NUM_DIGITS], "carry out of the top digit cell")
    // A digit position is always left while emitting.
    `ASSERT_IMPLIES(a_rem_nonzero, i_clk, i_rst_n, r_state == ST_EMIT,
        r_rem != '0, "emit state with no digit left")
    // The minus sign is only sent for a negative signed value.
    `ASSERT_IMPLIES(a_sign_neg, i_clk, i_rst_n, r_state == ST_SIGN,
        r_neg, "sign state on a non-negative value")
    // An accepted word always starts conversion or emission.
    `ASSERT_NEXT(a_accept_start, i_clk, i_rst_n, w_in_acc,
        (r_state == ST_CONV) || (r_state == ST_EMIT), "accepted word not started")

endmodule
